// ----- rtl/lztbp_pkg.sv -----
`timescale 1ns / 1ps
// shared types and constants for the lz token bit-stream packer
// no dependencies; imported by the packer top, front, fifo and back files
package lztbp_pkg;

  localparam int WORD_W      = 16;
  localparam int CHUNK_W     = 48;  // widest chunk handed from front to back
  localparam int CHUNK_LEN_W = 6;
  localparam int ACC_W       = 63;  // 15 leftover bits plus one full chunk
  localparam int QUEUE_DEPTH = 2;
  localparam int CFG_W       = 32;
  localparam int PRE_W       = 142;

  localparam logic [31:0] MAGIC = 32'h7670_6B30;
  // fixed code-tree description that closes the preamble
  localparam logic [69:0] TREE_BITS = {
    1'b0, 8'd1, 1'b0, 8'd3, 1'b0, 8'd10, 1'b0, 8'd16, 4'b1111,
    1'b0, 8'd2, 1'b0, 8'd4, 1'b0, 8'd8, 3'b111
  };

  typedef enum logic [1:0] {
    CMD_START   = 2'd0,
    CMD_LITERAL = 2'd1,
    CMD_MATCH   = 2'd2,
    CMD_END     = 2'd3
  } cmd_t;

  typedef enum logic {
    REG_SAMPLE_MODE   = 1'b0,
    REG_ORIGINAL_SIZE = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    FE_TOKEN = 2'd0,
    FE_PRE1  = 2'd1,
    FE_PRE2  = 2'd2
  } fe_state_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [7:0]  literal_byte;
    logic [15:0] match_offset;
    logic [7:0]  match_length;
  } token_t;

  typedef struct packed {
    logic [15:0] packed_word;
    logic        last_word;
  } word_t;

  // bits are right-aligned, oldest bit highest; pad asks the back end to fill
  // the partial word with zeros
  typedef struct packed {
    logic [CHUNK_W-1:0]     bits;
    logic [CHUNK_LEN_W-1:0] len;
    logic                   pad;
    logic                   last;
  } chunk_t;

  typedef struct packed {
    logic [18:0] bits;
    logic [4:0]  len;
  } vclass_t;

  // prefix class by bit length: 1, 3, 10 or 16 payload bits
  function automatic vclass_t value_class(input logic [15:0] v);
    vclass_t r;
    if (v < 16'd2) begin
      r.bits = 19'(v[0]);
      r.len  = 5'd2;
    end else if (v < 16'd8) begin
      r.bits = 19'({2'b10, v[2:0]});
      r.len  = 5'd5;
    end else if (v < 16'd1024) begin
      r.bits = 19'({3'b110, v[9:0]});
      r.len  = 5'd13;
    end else begin
      r.bits = {3'b111, v};
      r.len  = 5'd19;
    end
    return r;
  endfunction

  function automatic logic [PRE_W-1:0] preamble(input logic [31:0] size,
                                                input logic [7:0] mode);
    return {MAGIC, size, mode, TREE_BITS};
  endfunction

endpackage

// ----- rtl/lztbp_stream_if.sv -----
`timescale 1ns / 1ps
// valid/ready channel carrying one payload word per handshake
// payload type comes in as a parameter; no other dependencies
interface lztbp_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/lz_token_bitstream_packer.sv -----
`timescale 1ns / 1ps
// throughput: one 16-bit word per cycle out of the back-end accumulator while the output is
// ready; a literal or match goes to the back end as one chunk, a start item as three chunks
// from the front end and eight or nine words
// reset: synchronous, clears the accumulator count, queue, handshakes and config registers
// depends on lztbp_pkg, lztbp_stream_if, lztbp_front, lztbp_fifo, lztbp_back
module lz_token_bitstream_packer #(
  parameter int QUEUE_DEPTH = lztbp_pkg::QUEUE_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  lztbp_pkg::reg_idx_t         cfg_index,
  input  logic [lztbp_pkg::CFG_W-1:0] cfg_data,
  lztbp_stream_if.sink                in_ch,
  lztbp_stream_if.source              out_ch
);
  import lztbp_pkg::*;

  lztbp_stream_if #(.payload_t(chunk_t)) front_q ();
  lztbp_stream_if #(.payload_t(chunk_t)) q_back ();

  lztbp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_ch    (in_ch),
    .chunk_ch (front_q)
  );

  lztbp_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk  (clk),
    .rst  (rst),
    .wr_ch(front_q),
    .rd_ch(q_back)
  );

  lztbp_back u_back (
    .clk     (clk),
    .rst     (rst),
    .chunk_ch(q_back),
    .out_ch  (out_ch)
  );

endmodule

// ----- rtl/lztbp_front.sv -----
`timescale 1ns / 1ps
// front end: takes tokens, holds the configuration and turns each token
// into one or more code chunks; uses lztbp_pkg and lztbp_stream_if
module lztbp_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  lztbp_pkg::reg_idx_t   cfg_index,
  input  logic [lztbp_pkg::CFG_W-1:0] cfg_data,
  lztbp_stream_if.sink          in_ch,
  lztbp_stream_if.source        chunk_ch
);
  import lztbp_pkg::*;

  logic [7:0]       sample_mode;
  logic [31:0]      original_size;
  fe_state_t        state, state_next;
  logic [PRE_W-1:0] pre;
  chunk_t           tok_chunk;
  vclass_t          off_vc;
  logic [CHUNK_W-1:0] code;
  logic [CHUNK_LEN_W-1:0] clen;
  logic [4:0]       rem_code;
  logic [2:0]       rem_len;
  logic [9:0]       len_code;
  logic [3:0]       len_len;
  logic [1:0]       rem1;
  logic [16:0]      off_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_mode   <= '0;
      original_size <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SAMPLE_MODE:   sample_mode   <= cfg_data[7:0];
        REG_ORIGINAL_SIZE: original_size <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  assign pre = preamble(original_size, sample_mode);

  // match code assembly and the first chunk of each token
  always_comb begin
    rem1     = in_ch.data.match_offset[1:0] - 2'd1;
    off_sum  = {1'b0, in_ch.data.match_offset} + 17'd8;
    rem_code = '0;
    rem_len  = '0;
    if (sample_mode == 8'd0) begin
      off_vc = value_class(in_ch.data.match_offset);
    end else begin
      off_vc = value_class(16'(off_sum >> 2));
      if (in_ch.data.match_offset[1:0] != 2'd0) begin
        if (rem1 < 2'd2) begin
          rem_code = 5'(rem1[0]);
          rem_len  = 3'd2;
        end else begin
          rem_code = {2'b10, 3'(rem1)};
          rem_len  = 3'd5;
        end
      end
    end
    if (in_ch.data.match_length < 8'd4) begin
      len_code = 10'(in_ch.data.match_length[1:0]);
      len_len  = 4'd3;
    end else if (in_ch.data.match_length < 8'd16) begin
      len_code = 10'({2'b10, in_ch.data.match_length[3:0]});
      len_len  = 4'd6;
    end else begin
      len_code = {2'b11, in_ch.data.match_length};
      len_len  = 4'd10;
    end
    code = CHUNK_W'(1);
    clen = CHUNK_LEN_W'(1);
    code = (code << rem_len) | CHUNK_W'(rem_code);
    clen = clen + CHUNK_LEN_W'(rem_len);
    code = (code << off_vc.len) | CHUNK_W'(off_vc.bits);
    clen = clen + CHUNK_LEN_W'(off_vc.len);
    code = (code << len_len) | CHUNK_W'(len_code);
    clen = clen + CHUNK_LEN_W'(len_len);

    tok_chunk.last = 1'b1;
    tok_chunk.pad  = 1'b0;
    case (in_ch.data.cmd)
      CMD_START: begin
        tok_chunk.bits = pre[PRE_W-1 -: CHUNK_W];
        tok_chunk.len  = CHUNK_LEN_W'(CHUNK_W);
        tok_chunk.last = 1'b0;
      end
      CMD_LITERAL: begin
        tok_chunk.bits = CHUNK_W'({1'b0, in_ch.data.literal_byte});
        tok_chunk.len  = CHUNK_LEN_W'(9);
      end
      CMD_MATCH: begin
        tok_chunk.bits = code;
        tok_chunk.len  = clen;
      end
      CMD_END: begin
        tok_chunk.bits = '0;
        tok_chunk.len  = '0;
        tok_chunk.pad  = 1'b1;
      end
      default: begin
        tok_chunk.bits = '0;
        tok_chunk.len  = '0;
      end
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      FE_TOKEN:
        if (in_ch.valid && chunk_ch.ready && in_ch.data.cmd == CMD_START)
          state_next = FE_PRE1;
      FE_PRE1:
        if (chunk_ch.ready) state_next = FE_PRE2;
      FE_PRE2:
        if (chunk_ch.ready) state_next = FE_TOKEN;
      default: state_next = FE_TOKEN;
    endcase
  end

  // outputs
  always_comb begin
    in_ch.ready    = 1'b0;
    chunk_ch.valid = 1'b0;
    chunk_ch.data  = tok_chunk;
    case (state)
      FE_TOKEN: begin
        in_ch.ready    = chunk_ch.ready;
        chunk_ch.valid = in_ch.valid;
      end
      FE_PRE1: begin
        chunk_ch.valid     = 1'b1;
        chunk_ch.data.bits = pre[PRE_W-CHUNK_W-1 -: CHUNK_W];
        chunk_ch.data.len  = CHUNK_LEN_W'(CHUNK_W);
        chunk_ch.data.pad  = 1'b0;
        chunk_ch.data.last = 1'b0;
      end
      FE_PRE2: begin
        chunk_ch.valid     = 1'b1;
        chunk_ch.data.bits = CHUNK_W'(pre[PRE_W-2*CHUNK_W-1:0]);
        chunk_ch.data.len  = CHUNK_LEN_W'(PRE_W - 2*CHUNK_W);
        chunk_ch.data.pad  = 1'b0;
        chunk_ch.data.last = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= FE_TOKEN;
    else     state <= state_next;
  end

endmodule

// ----- rtl/lztbp_fifo.sv -----
`timescale 1ns / 1ps
// short chunk queue between front and back end
// uses lztbp_pkg and lztbp_stream_if
module lztbp_fifo #(
  parameter int DEPTH = lztbp_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  lztbp_stream_if.sink   wr_ch,
  lztbp_stream_if.source rd_ch
);
  import lztbp_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  chunk_t           mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             push, pop;

  assign wr_ch.ready = (fill != CNT_W'(DEPTH));
  assign rd_ch.valid = (fill != '0);
  assign rd_ch.data  = mem[rd_ptr];
  assign push        = wr_ch.valid && wr_ch.ready;
  assign pop         = rd_ch.valid && rd_ch.ready;

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wr_ch.data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)      fill <= fill + 1'b1;
      else if (pop && !push) fill <= fill - 1'b1;
    end
  end

endmodule

// ----- rtl/lztbp_back.sv -----
`timescale 1ns / 1ps
// back end: bit accumulator that appends chunks and cuts 16-bit words
// uses lztbp_pkg and lztbp_stream_if
module lztbp_back (
  input  logic           clk,
  input  logic           rst,
  lztbp_stream_if.sink   chunk_ch,
  lztbp_stream_if.source out_ch
);
  import lztbp_pkg::*;

  logic [ACC_W-1:0]       acc, acc_next;
  logic [CHUNK_LEN_W-1:0] cnt, cnt_next, cnt_rem, pad_len, add_len;
  logic                   mark, mark_next;
  logic                   emit, take;
  logic                   out_valid;
  word_t                  out_word;

  assign emit    = (cnt >= CHUNK_LEN_W'(WORD_W)) && (!out_valid || out_ch.ready);
  assign cnt_rem = emit ? cnt - CHUNK_LEN_W'(WORD_W) : cnt;
  // new chunk joins only once every complete word has left
  assign chunk_ch.ready = (cnt_rem < CHUNK_LEN_W'(WORD_W));
  assign take    = chunk_ch.valid && chunk_ch.ready;
  assign pad_len = (cnt_rem == '0) ? '0 : CHUNK_LEN_W'(WORD_W) - cnt_rem;
  assign add_len = chunk_ch.data.pad ? pad_len : chunk_ch.data.len;

  always_comb begin
    acc_next  = acc;
    cnt_next  = cnt_rem;
    mark_next = mark;
    if (take) begin
      acc_next  = (acc << add_len)
                | (chunk_ch.data.pad ? '0 : ACC_W'(chunk_ch.data.bits));
      cnt_next  = cnt_rem + add_len;
      mark_next = chunk_ch.data.last;
    end
  end

  always_ff @(posedge clk) begin
    acc <= acc_next;
    if (emit) begin
      out_word.packed_word <= 16'(acc >> (cnt - CHUNK_LEN_W'(WORD_W)));
      // the final complete word of the item closes it
      out_word.last_word   <= mark && (cnt < CHUNK_LEN_W'(2*WORD_W));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      mark      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      cnt  <= cnt_next;
      mark <= mark_next;
      if (emit)              out_valid <= 1'b1;
      else if (out_ch.ready) out_valid <= 1'b0;
    end
  end

  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_word;

  a_take_empty: assert property (@(posedge clk) disable iff (rst)
    take |-> cnt_rem < CHUNK_LEN_W'(WORD_W))
    else $error("chunk appended while a full word was pending");

  a_last_drains: assert property (@(posedge clk) disable iff (rst)
    (emit && mark && cnt < CHUNK_LEN_W'(2*WORD_W) && !take)
      |=> cnt < CHUNK_LEN_W'(WORD_W))
    else $error("complete word left behind after last word of an item");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> (cnt == '0) && !out_valid)
    else $error("accumulator not cleared by reset");

endmodule
